// ===== rtl/int_to_decimal_ascii_top_assert.svh =====
// Assertion macros for the signed integer to decimal ASCII converter.
// Included by the modules that assert; no other dependencies.
`ifndef INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define ITDA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define ITDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/itoda_pkg.sv =====
// Package for the integer to decimal ASCII converter: types, character codes,
// and the digit-count helper. No dependencies.
package itoda_pkg;

    // Default input width
    localparam int unsigned VALUE_BITS_DEF = 32;

    // Character codes on the 6-bit output
    localparam logic [5:0] CHAR_ZERO  = 6'd48;
    localparam logic [5:0] CHAR_MINUS = 6'd45;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_SKIP,
        ST_EMIT
    } itoda_state_t;

    // Commands to the shift-and-adjust unit
    typedef struct packed {
        logic load;        // load magnitude, clear BCD
        logic conv_step;   // one double-dabble step
        logic digit_shift; // drop the top BCD digit
    } itoda_ctrl_t;

    // Decimal digits of 2^(bits-1): floor((bits-1)*log10(2)) + 1, exact for 8..64
    function automatic int unsigned digit_count(input int unsigned bits);
        return ((bits - 1) * 30103) / 100000 + 1;
    endfunction

endpackage

// ===== rtl/itoda_dabble.sv =====
// Shift-and-add-3 binary to BCD unit, one input bit per step.
// Depends on itoda_pkg (itoda_ctrl_t).
module itoda_dabble #(
    parameter int unsigned VALUE_BITS = itoda_pkg::VALUE_BITS_DEF,
    parameter int unsigned NDIG       = itoda_pkg::digit_count(VALUE_BITS)
) (
    input  logic                   clk,
    input  itoda_pkg::itoda_ctrl_t ctrl,
    input  logic [VALUE_BITS-1:0]  mag,
    output logic [3:0]             top_digit
);

    localparam int unsigned BCD_W = NDIG * 4;

    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [BCD_W-1:0]      adj;

    // Add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int d = 0; d < NDIG; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
                adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            else
                adj[4*d +: 4] = bcd_reg[4*d +: 4];
        end
    end

    // Next value of the shift pair
    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        priority if (ctrl.load)
        begin
            bin_next = mag;
            bcd_next = '0;
        end
        else if (ctrl.conv_step)
        begin
            {bcd_next, bin_next} = {adj, bin_reg} << 1;
        end
        else if (ctrl.digit_shift)
        begin
            bcd_next = bcd_reg << 4;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign top_digit = bcd_reg[BCD_W-1 -: 4];

endmodule

// ===== rtl/int_to_decimal_ascii_top.sv =====
// Top level of the signed integer to decimal ASCII converter.
// Depends on itoda_pkg, itoda_dabble and int_to_decimal_ascii_top_assert.svh.

// Converts one VALUE_BITS-bit two's complement word into its decimal text, one
// ASCII character per output word, '-' first for negatives, no leading zeros,
// last set on the final digit. Each input word is accepted, then goes through
// VALUE_BITS steps of the shared shift-and-add-3 unit, one sign slot, the
// leading-zero skip, then one BCD digit slot at a time, either dropping a
// leading zero or emitting a character. in_ready is high only between words;
// output stalls stretch the sign and emit states. A one-word output register
// lets the last character wait while the next word is accepted.
module int_to_decimal_ascii_top #(
    parameter int unsigned VALUE_BITS = itoda_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [5:0]            char_code,
    output logic                  last
);

`include "int_to_decimal_ascii_top_assert.svh"

    localparam int unsigned NDIG  = itoda_pkg::digit_count(VALUE_BITS);
    localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);
    localparam int unsigned REM_W = $clog2(NDIG + 1);

    itoda_pkg::itoda_state_t state_reg, state_next;
    logic                    neg_reg, neg_next;
    logic [CNT_W-1:0]        bit_cnt_reg, bit_cnt_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic                    out_valid_reg, out_valid_next;
    logic [5:0]              char_reg, char_next;
    logic                    last_reg, last_next;

    itoda_pkg::itoda_ctrl_t  ctrl;
    logic [VALUE_BITS-1:0]   mag;
    logic [3:0]              top_digit;
    logic                    in_fire;
    logic                    slot_free;

    assign in_ready  = (state_reg == itoda_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // Magnitude as unsigned, so the most negative value needs no extra bit
    assign mag = value[VALUE_BITS-1] ? (~value + 1'b1) : value;

    itoda_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG)
    ) u_dabble (
        .clk       (clk),
        .ctrl      (ctrl),
        .mag       (mag),
        .top_digit (top_digit)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            itoda_pkg::ST_IDLE:
                if (in_valid)
                    state_next = itoda_pkg::ST_CONV;
            itoda_pkg::ST_CONV:
                if (bit_cnt_reg == CNT_W'(1))
                    state_next = itoda_pkg::ST_SIGN;
            itoda_pkg::ST_SIGN:
                if (!neg_reg || slot_free)
                    state_next = itoda_pkg::ST_SKIP;
            itoda_pkg::ST_SKIP:
                if (!(top_digit == 4'd0 && rem_reg > REM_W'(1)))
                    state_next = itoda_pkg::ST_EMIT;
            itoda_pkg::ST_EMIT:
                if (slot_free && rem_reg == REM_W'(1))
                    state_next = itoda_pkg::ST_IDLE;
            default:
                state_next = itoda_pkg::ST_IDLE;
        endcase
    end

    // Datapath commands, counters and output register
    always_comb
    begin
        ctrl           = '0;
        neg_next       = neg_reg;
        bit_cnt_next   = bit_cnt_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !out_ready;
        char_next      = char_reg;
        last_next      = last_reg;
        unique case (state_reg)
            itoda_pkg::ST_IDLE:
                if (in_valid)
                begin
                    ctrl.load    = 1'b1;
                    neg_next     = value[VALUE_BITS-1];
                    bit_cnt_next = CNT_W'(VALUE_BITS);
                    rem_next     = REM_W'(NDIG);
                end
            itoda_pkg::ST_CONV:
            begin
                ctrl.conv_step = 1'b1;
                bit_cnt_next   = bit_cnt_reg - CNT_W'(1);
            end
            itoda_pkg::ST_SIGN:
                if (neg_reg && slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = itoda_pkg::CHAR_MINUS;
                    last_next      = 1'b0;
                end
            itoda_pkg::ST_SKIP:
                // drop leading zeros, keep at least one digit
                if (top_digit == 4'd0 && rem_reg > REM_W'(1))
                begin
                    ctrl.digit_shift = 1'b1;
                    rem_next         = rem_reg - REM_W'(1);
                end
            itoda_pkg::ST_EMIT:
                if (slot_free)
                begin
                    ctrl.digit_shift = 1'b1;
                    rem_next         = rem_reg - REM_W'(1);
                    out_valid_next   = 1'b1;
                    char_next        = itoda_pkg::CHAR_ZERO + {2'b00, top_digit};
                    last_next        = (rem_reg == REM_W'(1));
                end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= itoda_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            rem_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            rem_reg       <= rem_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

    // Checks
    `ITDA_ASSERT_NEXT(a_accept_starts_conv, clk, rst_n, in_fire,
        state_reg == itoda_pkg::ST_CONV, "accepted word did not start conversion")
    `ITDA_ASSERT_NOW(a_char_legal, clk, rst_n, out_valid,
        (char_code == itoda_pkg::CHAR_MINUS) ||
        (char_code >= itoda_pkg::CHAR_ZERO && char_code <= itoda_pkg::CHAR_ZERO + 6'd9),
        "illegal character code")
    `ITDA_ASSERT_NOW(a_minus_not_last, clk, rst_n,
        out_valid && char_code == itoda_pkg::CHAR_MINUS, !last, "minus sign flagged last")
    `ITDA_ASSERT_NEXT(a_last_digit_ends, clk, rst_n,
        state_reg == itoda_pkg::ST_EMIT && slot_free && rem_reg == REM_W'(1),
        state_reg == itoda_pkg::ST_IDLE && out_valid && last,
        "final digit did not end the word")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for int_to_decimal_ascii_top: drives signed 32-bit words
// and checks the ASCII decimal text that comes back, one character per word.
// Depends on itoda_pkg and the int_to_decimal_ascii_top RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned VBITS = itoda_pkg::VALUE_BITS_DEF;

    // One output character as the block should present it
    typedef struct packed {
        logic [5:0] code;
        logic       last;
    } char_word_t;

    // One stimulus word: value, idle cycles before it, and whether to drain first
    typedef struct {
        logic [VBITS-1:0] v;
        int               gap;
        bit               drain;
    } stim_t;

    // Expected-character store and the decimal text predictor
    class ascii_scoreboard;
        char_word_t pending_chars[$];
        int         words_in;
        int         mismatches;

        function new();
            words_in   = 0;
            mismatches = 0;
        endfunction

        // Queue the decimal text of one accepted word
        function void note_word(logic [VBITS-1:0] v);
            logic [VBITS-1:0] mag;
            logic [3:0]       digits[$];
            bit               neg;
            char_word_t       c;
            neg = v[VBITS-1];
            // two's complement negation wraps cleanly for the most negative value
            mag = neg ? (~v + 1'b1) : v;
            do
            begin
                digits.push_front(4'(mag % 10));
                mag = mag / 10;
            end
            while (mag != 0);
            if (neg)
            begin
                c.code = itoda_pkg::CHAR_MINUS;
                c.last = 1'b0;
                pending_chars.push_back(c);
            end
            foreach (digits[i])
            begin
                c.code = itoda_pkg::CHAR_ZERO + {2'b00, digits[i]};
                c.last = (i == digits.size() - 1);
                pending_chars.push_back(c);
            end
            words_in++;
        endfunction

        // Compare one accepted character with the oldest expectation
        function void check_word(logic [5:0] code, logic last);
            char_word_t want;
            if (pending_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected char: code=%0d last=%0b", code, last);
                return;
            end
            want = pending_chars.pop_front();
            if (code !== want.code || last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("char mismatch: expected code=%0d last=%0b, got code=%0d last=%0b",
                             want.code, want.last, code, last);
            end
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction

        // Anything still queued at the end never showed up
        function void close_out();
            if (pending_chars.size() != 0)
            begin
                mismatches += pending_chars.size();
                $display("%0d expected chars never arrived", pending_chars.size());
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [VBITS-1:0] value;
    logic             out_valid;
    logic             out_ready;
    logic [5:0]       char_code;
    logic             last;

    ascii_scoreboard  board;
    stim_t            stim_q[$];
    bit               sink_hold;

    int_to_decimal_ascii_top #(.VALUE_BITS(VBITS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_code (char_code),
        .last      (last)
    );

    // 10 ns clock
    always #5 clk = ~clk;

    // Queue one stimulus word
    function automatic void add_word(logic [VBITS-1:0] v, int gap, bit drain);
        stim_t s;
        s.v     = v;
        s.gap   = (drain && gap == 0) ? 1 : gap;
        s.drain = drain;
        stim_q.push_back(s);
    endfunction

    // Random value: half full range, the rest short numbers and powers of ten or one below
    function automatic logic [VBITS-1:0] pick_value();
        logic [VBITS-1:0] v;
        int               kind;
        int               n;
        longint           p;
        kind = $urandom_range(0, 9);
        n    = $urandom_range(1, 9);
        p    = 1;
        repeat (n) p = p * 10;
        if (kind <= 4)
            v = $urandom;
        else if (kind <= 7)
            v = VBITS'($urandom_range(0, int'(p - 1)));
        else
            v = VBITS'(p - $urandom_range(0, 1));
        if (kind > 4 && $urandom_range(0, 1))
            v = ~v + 1'b1;
        return v;
    endfunction

    // Sender: offers every stimulus word, holding value steady until accepted
    task automatic run_sender();
        int k;
        for (k = 0; k < stim_q.size(); k++)
        begin
            if (stim_q[k].gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (stim_q[k].gap) @(posedge clk);
                if (stim_q[k].drain)
                    while (board.pending() != 0) @(posedge clk);
            end
            in_valid <= 1'b1;
            value    <= stim_q[k].v;
            do @(posedge clk); while (!in_ready);
            board.note_word(stim_q[k].v);
        end
        in_valid <= 1'b0;
    endtask

    // Receiver: random stalls per word, calm stretches, and the long hold-off
    task automatic run_receiver();
        int stall;
        bit hold;
        forever
        begin
            if (((board.words_in / 16) % 3) == 1)
                stall = 0;
            else
                stall = $urandom_range(0, 15);
            hold = sink_hold;
            if (stall > 0 || hold)
            begin
                out_ready <= 1'b0;
                repeat ((stall == 0) ? 1 : stall) @(posedge clk);
                while (sink_hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            board.check_word(char_code, last);
        end
    endtask

    // Long output hold-off while the sender keeps offering words
    initial
    begin
        sink_hold = 1'b0;
        wait (rst_n === 1'b1);
        while (board.words_in < 30) @(posedge clk);
        sink_hold = 1'b1;
        repeat (400) @(posedge clk);
        sink_hold = 1'b0;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Main sequence
    initial
    begin
        int k;
        int gap;
        logic [VBITS-1:0] directed[$];

        board     = new();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        value     <= '0;
        out_ready <= 1'b0;

        // Directed: zero, single digits, powers of ten, extremes, bit patterns
        directed = '{32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99,
                     32'd100, -32'sd100, 32'd12345, -32'sd67890, 32'd999999999,
                     32'd1000000000, -32'sd1000000000, 32'h7FFFFFFF, 32'h80000001,
                     32'h80000000, 32'd1234567890, -32'sd1234567890, 32'h55555555,
                     32'hAAAAAAAA};
        foreach (directed[i])
            add_word(directed[i], $urandom_range(0, 15), 1'b0);

        // Random part; gaps drop to zero in calm stretches and around the hold-off
        for (k = 0; k < 88; k++)
        begin
            gap = $urandom_range(0, 15);
            if (((k / 16) % 3) == 2 || (k >= 6 && k < 24))
                gap = 0;
            add_word(pick_value(), gap, (k == 0 || k == 70));
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        fork
            run_receiver();
        join_none

        run_sender();
        while (board.pending() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        board.close_out();

        if (board.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
